// ----- rtl/core/dccd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccd_pkg: shared types, constants and microcode for the day count converter
// Holds the payload structs, the sequencer opcodes and conditions, the
// microprogram ROM and the month length table.
// ----------------------------------------------------------------------------
package dccd_pkg;

  // Field widths
  localparam int DAY_COUNT_BITS = 15;
  localparam int MINUTE_BITS    = 11;
  localparam int YEAR_BITS      = 12;
  localparam int YLEN_BITS      = 9;
  localparam int MLEN_BITS      = 5;

  // Calendar constants
  localparam logic [YEAR_BITS-1:0] BASE_YEAR     = 12'd1980;
  localparam logic [1:0]           BASE_MOD4     = 2'd0;    // 1980 mod 4
  localparam logic [6:0]           BASE_MOD100   = 7'd80;   // 1980 mod 100
  localparam logic [8:0]           BASE_MOD400   = 9'd380;  // 1980 mod 400
  localparam logic [6:0]           MOD100_LAST   = 7'd99;
  localparam logic [8:0]           MOD400_LAST   = 9'd399;
  localparam logic [3:0]           LAST_MONTH    = 4'd12;
  localparam logic [YLEN_BITS-1:0] YEAR_DAYS     = 9'd365;
  localparam logic [YLEN_BITS-1:0] LEAP_DAYS     = 9'd366;
  localparam int                   DAYS_PER_WEEK = 7;
  localparam int                   MIN_PER_HOUR  = 60;

  // Reciprocals: floor(x/7) exact for x < 104859, floor(x/60) exact for x < 4681
  localparam int                   WD_X_BITS    = DAY_COUNT_BITS + 1;
  localparam logic [16:0]          WD_RECIP     = 17'd74899;
  localparam int                   WD_SHIFT     = 19;
  localparam int                   WD_PROD_BITS = WD_X_BITS + 17;
  localparam int                   WD_Q_BITS    = WD_PROD_BITS - WD_SHIFT;
  localparam logic [12:0]          HR_RECIP     = 13'd4370;
  localparam int                   HR_SHIFT     = 18;
  localparam int                   HR_PROD_BITS = MINUTE_BITS + 13;

  // Payload types
  typedef struct packed {
    logic [DAY_COUNT_BITS-1:0] day_count;
    logic [MINUTE_BITS-1:0]    minute_of_day;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [3:0]           month;
    logic [4:0]           day_of_month;
    logic [2:0]           weekday;
    logic [5:0]           hour;
    logic [5:0]           minute;
  } out_item_t;

  // Datapath operations
  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_YEAR_SUB = 3'd1;
  localparam logic [2:0] OP_DAY_INC  = 3'd2;
  localparam logic [2:0] OP_MON_SUB  = 3'd3;
  localparam logic [2:0] OP_EMIT     = 3'd4;

  // Branch conditions
  localparam logic [1:0] COND_NEVER     = 2'd0;
  localparam logic [1:0] COND_YEAR_FITS = 2'd1;
  localparam logic [1:0] COND_MON_DONE  = 2'd2;
  localparam logic [1:0] COND_OUT_FULL  = 2'd3;

  // Program counter
  localparam int         PC_BITS      = 2;
  localparam logic [1:0] PC_YEAR_LOOP = 2'd0;
  localparam logic [1:0] PC_DAY_INC   = 2'd1;
  localparam logic [1:0] PC_MON_LOOP  = 2'd2;
  localparam logic [1:0] PC_FINISH    = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         cond;
    logic [PC_BITS-1:0] jt;   // next step when condition holds (op skipped)
    logic [PC_BITS-1:0] jf;   // next step when it does not (op executed)
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic       load;
    logic [2:0] op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic year_fits;
    logic month_done;
  } dp_stat_t;

  // Microprogram ROM
  function automatic uword_t ucode_rom(input logic [PC_BITS-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_YEAR_LOOP: w = '{op: OP_YEAR_SUB, cond: COND_YEAR_FITS,
                          jt: PC_DAY_INC,  jf: PC_YEAR_LOOP};
      PC_DAY_INC:   w = '{op: OP_DAY_INC,  cond: COND_NEVER,
                          jt: PC_MON_LOOP, jf: PC_MON_LOOP};
      PC_MON_LOOP:  w = '{op: OP_MON_SUB,  cond: COND_MON_DONE,
                          jt: PC_FINISH,   jf: PC_MON_LOOP};
      PC_FINISH:    w = '{op: OP_EMIT,     cond: COND_OUT_FULL,
                          jt: PC_FINISH,   jf: PC_YEAR_LOOP};
      default:      w = '{op: OP_NOP,      cond: COND_NEVER,
                          jt: PC_YEAR_LOOP, jf: PC_YEAR_LOOP};
    endcase
    return w;
  endfunction

  // Days in a month, February by the leap flag
  function automatic logic [MLEN_BITS-1:0] month_len(input logic [3:0] month,
                                                      input logic       leap);
    logic [MLEN_BITS-1:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/day_count_to_calendar_date.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_to_calendar_date: day count and minute count to date and time
// Microcoded converter: a four-step program subtracts year lengths, then
// month lengths, and emits year, month, day, weekday, hour and minute.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | payload
//  --------+-------------------------------+----------------------
//  input   | in_valid / in_ready / in_data | dccd_pkg::in_item_t
//  output  | out_valid / out_ready / out_data | dccd_pkg::out_item_t
//
// One transaction at a time: the sequencer runs its year subtraction loop,
// day increment step, month loop and emit step before it accepts the next input.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled output holds its result; the sequencer waits in its final step
// and takes no new input until the result slot frees.
// ----------------------------------------------------------------------------
module day_count_to_calendar_date (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dccd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dccd_pkg::out_item_t  out_data
);

  dccd_pkg::ctrl_t     ctrl;
  dccd_pkg::dp_stat_t  stat;
  dccd_pkg::out_item_t result;
  logic                busy;
  logic                start;
  logic                out_full;
  logic                out_valid_r;
  dccd_pkg::out_item_t out_data_r;

  assign start    = in_valid && in_ready;
  assign in_ready = !busy;
  assign out_full = out_valid_r && !out_ready;

  dccd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .stat     (stat),
    .out_full (out_full),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  dccd_dp u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_item (in_data),
    .stat    (stat),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == dccd_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == dccd_pkg::OP_EMIT) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Accepting a transaction starts the program, so input closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accept");

  // Emit never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == dccd_pkg::OP_EMIT) |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // Emitted dates are in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.month >= 4'd1 && out_data.month <= 4'd12 &&
                   out_data.day_of_month >= 5'd1 &&
                   out_data.weekday >= 3'd1 && out_data.weekday <= 3'd7))
    else $error("date field out of range");

  // Results appear only from an emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.op == dccd_pkg::OP_EMIT))
    else $error("result without emit");
`endif

endmodule

// ----- rtl/core/dccd_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccd_seq: microcode sequencer
// Steps through the ROM program, evaluates the branch condition of each
// control word and issues the datapath operation when it does not branch.
// ----------------------------------------------------------------------------
module dccd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dccd_pkg::dp_stat_t  stat,
  input  logic                out_full,
  output dccd_pkg::ctrl_t     ctrl,
  output logic                busy
);

  logic                         busy_r, busy_nxt;
  logic [dccd_pkg::PC_BITS-1:0] pc_r, pc_nxt;
  dccd_pkg::uword_t             uw;
  logic                         taken;
  logic [2:0]                   op_act;

  // Fetch and condition select
  always_comb begin
    uw = dccd_pkg::ucode_rom(pc_r);
    unique case (uw.cond)
      dccd_pkg::COND_YEAR_FITS: taken = stat.year_fits;
      dccd_pkg::COND_MON_DONE:  taken = stat.month_done;
      dccd_pkg::COND_OUT_FULL:  taken = out_full;
      default:                  taken = 1'b0;
    endcase
    op_act = (busy_r && !taken) ? uw.op : dccd_pkg::OP_NOP;
  end

  // Next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = dccd_pkg::PC_YEAR_LOOP;
    end else if (busy_r) begin
      pc_nxt = taken ? uw.jt : uw.jf;
      if (op_act == dccd_pkg::OP_EMIT) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= dccd_pkg::PC_YEAR_LOOP;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctrl.load = start;
  assign ctrl.op   = op_act;
  assign busy      = busy_r;

endmodule

// ----- rtl/core/dccd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccd_dp: conversion datapath
// Day remainder, year and month counters with leap tracking, plus
// reciprocal units for weekday and hour/minute.
// ----------------------------------------------------------------------------
module dccd_dp (
  input  logic                 clk,
  input  dccd_pkg::ctrl_t      ctrl,
  input  dccd_pkg::in_item_t   in_item,
  output dccd_pkg::dp_stat_t   stat,
  output dccd_pkg::out_item_t  result
);

  localparam int DCB = dccd_pkg::DAY_COUNT_BITS;

  logic [DCB-1:0]                   day0_r;
  logic [dccd_pkg::MINUTE_BITS-1:0] mins_r;
  logic [DCB-1:0]                   rem_r, rem_nxt;
  logic [dccd_pkg::YEAR_BITS-1:0]   year_r, year_nxt;
  logic [1:0]                       mod4_r, mod4_nxt;
  logic [6:0]                       mod100_r, mod100_nxt;
  logic [8:0]                       mod400_r, mod400_nxt;
  logic [3:0]                       month_r, month_nxt;

  logic                             leap;
  logic [dccd_pkg::YLEN_BITS-1:0]   ylen;
  logic [dccd_pkg::MLEN_BITS-1:0]   mlen;
  logic [DCB-1:0]                   ylen_x, mlen_x;

  // Leap rule from the running residues
  assign leap   = (mod4_r == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign ylen   = leap ? dccd_pkg::LEAP_DAYS : dccd_pkg::YEAR_DAYS;
  assign mlen   = dccd_pkg::month_len(month_r, leap);
  assign ylen_x = DCB'(ylen);
  assign mlen_x = DCB'(mlen);

  assign stat.year_fits  = rem_r < ylen_x;
  assign stat.month_done = (month_r == dccd_pkg::LAST_MONTH) || (rem_r <= mlen_x);

  // Counter updates per operation
  always_comb begin
    rem_nxt    = rem_r;
    year_nxt   = year_r;
    mod4_nxt   = mod4_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    month_nxt  = month_r;
    if (ctrl.load) begin
      rem_nxt    = in_item.day_count;
      year_nxt   = dccd_pkg::BASE_YEAR;
      mod4_nxt   = dccd_pkg::BASE_MOD4;
      mod100_nxt = dccd_pkg::BASE_MOD100;
      mod400_nxt = dccd_pkg::BASE_MOD400;
      month_nxt  = 4'd1;
    end else begin
      unique case (ctrl.op)
        dccd_pkg::OP_YEAR_SUB: begin
          rem_nxt    = rem_r - ylen_x;
          year_nxt   = year_r + 12'd1;
          mod4_nxt   = mod4_r + 2'd1;
          mod100_nxt = (mod100_r == dccd_pkg::MOD100_LAST) ? 7'd0 : mod100_r + 7'd1;
          mod400_nxt = (mod400_r == dccd_pkg::MOD400_LAST) ? 9'd0 : mod400_r + 9'd1;
        end
        dccd_pkg::OP_DAY_INC: begin
          rem_nxt = rem_r + DCB'(1);
        end
        dccd_pkg::OP_MON_SUB: begin
          rem_nxt   = rem_r - mlen_x;
          month_nxt = month_r + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      day0_r <= in_item.day_count;
      mins_r <= in_item.minute_of_day;
    end
    rem_r    <= rem_nxt;
    year_r   <= year_nxt;
    mod4_r   <= mod4_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    month_r  <= month_nxt;
  end

  // Weekday: (day + 1) mod 7 via reciprocal, quotient registered
  logic [dccd_pkg::WD_X_BITS-1:0]    wd_x;
  logic [dccd_pkg::WD_PROD_BITS-1:0] wd_prod;
  logic [dccd_pkg::WD_Q_BITS-1:0]    wd_q_r;
  logic [dccd_pkg::WD_X_BITS-1:0]    wd_rem;

  assign wd_x    = dccd_pkg::WD_X_BITS'(day0_r) + dccd_pkg::WD_X_BITS'(1);
  assign wd_prod = dccd_pkg::WD_PROD_BITS'(wd_x) * dccd_pkg::WD_PROD_BITS'(dccd_pkg::WD_RECIP);

  // Hour: minutes / 60 via reciprocal, registered
  logic [dccd_pkg::HR_PROD_BITS-1:0] hr_prod;
  logic [5:0]                        hour_r;
  logic [dccd_pkg::MINUTE_BITS:0]    min_rem;

  assign hr_prod = dccd_pkg::HR_PROD_BITS'(mins_r) * dccd_pkg::HR_PROD_BITS'(dccd_pkg::HR_RECIP);

  // Inputs settle on load; these registers follow in the next cycle, well before emit
  always_ff @(posedge clk) begin
    wd_q_r <= wd_prod[dccd_pkg::WD_PROD_BITS-1:dccd_pkg::WD_SHIFT];
    hour_r <= hr_prod[dccd_pkg::HR_SHIFT+5:dccd_pkg::HR_SHIFT];
  end

  assign wd_rem  = wd_x - dccd_pkg::WD_X_BITS'(wd_q_r)
                        * dccd_pkg::WD_X_BITS'(dccd_pkg::DAYS_PER_WEEK);
  assign min_rem = (dccd_pkg::MINUTE_BITS+1)'(mins_r)
                 - (dccd_pkg::MINUTE_BITS+1)'(hour_r)
                   * (dccd_pkg::MINUTE_BITS+1)'(dccd_pkg::MIN_PER_HOUR);

  // Result fields
  assign result.year         = year_r;
  assign result.month        = month_r;
  assign result.day_of_month = rem_r[4:0];
  assign result.weekday      = wd_rem[2:0] + 3'd1;
  assign result.hour         = hour_r;
  assign result.minute       = min_rem[5:0];

endmodule
